// ----- hdl/bslru_pkg.sv -----
package bslru_pkg;

    // Input command codes carried in s_tuser.
    localparam logic CMD_ACCESS  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Action taken by the cells during the apply sweep.
    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_HIT,
        MODE_FREE,
        MODE_EVICT,
        MODE_RELEASE
    } mode_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_APPLY,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/buffer_slot_lru_replacer_top.sv -----
// Buffer slot LRU replacer. The block tracks SLOTS buffer slots, each with a used
// flag, an owner handle and an age (higher age means more recently used). An access
// transaction promotes the slot the handle already owns, otherwise takes the
// highest-index free slot, otherwise evicts the lowest-index slot of age zero and
// reports its previous owner; a release transaction frees the handle's slot. The
// state lives in a row of SLOTS identical cells. A record is passed from cell to
// cell, one cell per clock: a gather sweep collects the hit, free and age-zero
// candidates, then an apply sweep carries the decision back down the row while
// each cell updates itself. The block therefore accepts no new transaction until
// both sweeps over the cell row are done and the result has been loaded into the
// output register, which must first be free. One result transaction follows
// every input transaction; it is held in an output register, so a new input
// transaction can be accepted while the previous result still waits. There is no
// clearing pass after reset; all slots start free with age zero.
module buffer_slot_lru_replacer_top #(
    parameter int SLOTS       = 8,
    parameter int HANDLE_BITS = 8
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    s_tvalid,
    output logic                                                    s_tready,
    // Fields from bit 0: handle.
    input  logic [((HANDLE_BITS+7)/8)*8-1:0]                        s_tdata,
    // Fields from bit 0: command.
    input  logic [0:0]                                              s_tuser,
    output logic                                                    m_tvalid,
    input  logic                                                    m_tready,
    // Fields from bit 0: slot, granted, was_hit, evicted, evicted_handle.
    output logic [((($clog2(SLOTS)+3+HANDLE_BITS)+7)/8)*8-1:0]      m_tdata
);
    import bslru_pkg::*;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int OUT_RAW = IDX_W + 3 + HANDLE_BITS;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam logic [IDX_W:0] AGE_TOP = (IDX_W+1)'(SLOTS - 1);

    // Record handed from cell to cell. The first group is filled during the
    // gather sweep, the second group steers the apply sweep.
    typedef struct packed {
        logic                   valid;
        logic                   apply;
        logic [HANDLE_BITS-1:0] handle;
        logic                   hit_found;
        logic [IDX_W-1:0]       hit_idx;
        logic [IDX_W-1:0]       hit_age;
        logic [CNT_W-1:0]       used_cnt;
        logic                   free_found;
        logic [IDX_W-1:0]       free_idx;
        logic                   zero_found;
        logic [IDX_W-1:0]       zero_idx;
        logic [HANDLE_BITS-1:0] zero_owner;
        mode_t                  mode;
        logic                   take;
        logic [IDX_W-1:0]       tgt_idx;
        logic [IDX_W-1:0]       tgt_age;
        logic [IDX_W-1:0]       s_cnt;
    } rec_t;

    // Broadcast write of the promoted slot's final age.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] age;
    } fix_t;

    state_t state_reg, state_next;

    logic                   cmd_reg, cmd_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    mode_t                  mode_reg, mode_next;
    logic [IDX_W-1:0]       mine_reg, mine_next;
    logic [IDX_W-1:0]       res_slot_reg, res_slot_next;
    logic                   res_gr_reg, res_gr_next;
    logic                   res_hit_reg, res_hit_next;
    logic                   res_ev_reg, res_ev_next;
    logic [HANDLE_BITS-1:0] res_evh_reg, res_evh_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg, m_data_next;

    rec_t rec_chain [SLOTS+1];
    rec_t tail;
    rec_t gather_launch;
    rec_t apply_launch;
    fix_t fix;

    logic accept;
    logic decide;
    logic finish;
    logic out_load;

    // Decision taken from the gathered record.
    mode_t            dec_mode;
    logic             dec_take;
    logic [IDX_W-1:0] dec_tgt_idx;
    logic [IDX_W-1:0] dec_tgt_age;
    logic [IDX_W:0]   promo_sum;
    logic [IDX_W-1:0] promo_age;

    assign tail = rec_chain[SLOTS];

    // The cell row.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        bslru_cell #(
            .SLOTS       (SLOTS),
            .HANDLE_BITS (HANDLE_BITS),
            .IDX         (i),
            .rec_t       (rec_t),
            .fix_t       (fix_t)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .rec_in  (rec_chain[i]),
            .fix     (fix),
            .rec_out (rec_chain[i+1])
        );
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER:
            begin
                if (tail.valid)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (tail.valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_tready = 1'b0;
        decide   = 1'b0;
        finish   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_GATHER: decide   = tail.valid;
            ST_APPLY:  finish   = tail.valid;
            ST_DONE:   out_load = !m_valid_reg || m_tready;
            default:
            begin
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Decision from the gathered record.
    always_comb
    begin
        dec_mode      = MODE_NONE;
        dec_take      = 1'b0;
        dec_tgt_idx   = '0;
        dec_tgt_age   = '0;
        res_slot_next = '0;
        res_gr_next   = 1'b0;
        res_hit_next  = 1'b0;
        res_ev_next   = 1'b0;
        res_evh_next  = '0;
        if (cmd_reg == CMD_RELEASE)
        begin
            if (tail.hit_found)
            begin
                dec_mode      = MODE_RELEASE;
                dec_tgt_idx   = tail.hit_idx;
                res_slot_next = tail.hit_idx;
                res_gr_next   = 1'b1;
                res_hit_next  = 1'b1;
            end
        end
        else if (tail.hit_found)
        begin
            dec_mode      = MODE_HIT;
            dec_tgt_idx   = tail.hit_idx;
            dec_tgt_age   = tail.hit_age;
            res_slot_next = tail.hit_idx;
            res_gr_next   = 1'b1;
            res_hit_next  = 1'b1;
        end
        else if (tail.free_found)
        begin
            // A free slot exists, so the used count stays below SLOTS.
            dec_mode      = MODE_FREE;
            dec_tgt_idx   = tail.free_idx;
            dec_tgt_age   = tail.used_cnt[IDX_W-1:0];
            res_slot_next = tail.free_idx;
            res_gr_next   = 1'b1;
        end
        else
        begin
            // All slots used: evict the first slot of age zero, if any.
            dec_mode    = MODE_EVICT;
            dec_take    = tail.zero_found;
            dec_tgt_idx = tail.zero_idx;
            if (tail.zero_found)
            begin
                res_slot_next = tail.zero_idx;
                res_gr_next   = 1'b1;
                res_ev_next   = 1'b1;
                res_evh_next  = tail.zero_owner;
            end
        end
    end

    always_comb
    begin
        gather_launch        = '0;
        gather_launch.valid  = accept;
        gather_launch.handle = s_tdata[HANDLE_BITS-1:0];

        apply_launch         = '0;
        apply_launch.valid   = decide;
        apply_launch.apply   = 1'b1;
        apply_launch.handle  = handle_reg;
        apply_launch.mode    = dec_mode;
        apply_launch.take    = dec_take;
        apply_launch.tgt_idx = dec_tgt_idx;
        apply_launch.tgt_age = dec_tgt_age;

        rec_chain[0] = (state_reg == ST_GATHER) ? apply_launch : gather_launch;
    end

    // The promoted slot climbs by the number of used slots ranked above it.
    assign promo_sum = {1'b0, mine_reg} + {1'b0, tail.s_cnt};
    assign promo_age = (promo_sum > AGE_TOP) ? AGE_TOP[IDX_W-1:0] : promo_sum[IDX_W-1:0];

    always_comb
    begin
        fix.valid = finish && (mode_reg == MODE_HIT);
        fix.idx   = res_slot_reg;
        fix.age   = promo_age;
    end

    // Item and result registers.
    assign cmd_next    = accept ? s_tuser[0] : cmd_reg;
    assign handle_next = accept ? s_tdata[HANDLE_BITS-1:0] : handle_reg;
    assign mode_next   = decide ? dec_mode : mode_reg;
    assign mine_next   = decide ? tail.hit_age : mine_reg;

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({res_evh_reg, res_ev_reg, res_hit_reg,
                                   res_gr_reg, res_slot_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        handle_reg <= handle_next;
        mode_reg   <= mode_next;
        mine_reg   <= mine_next;
        m_data_reg <= m_data_next;
        if (decide)
        begin
            res_slot_reg <= res_slot_next;
            res_gr_reg   <= res_gr_next;
            res_hit_reg  <= res_hit_next;
            res_ev_reg   <= res_ev_next;
            res_evh_reg  <= res_evh_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- hdl/bslru_cell.sv -----
module bslru_cell #(
    parameter int  SLOTS       = 8,
    parameter int  HANDLE_BITS = 8,
    parameter int  IDX         = 0,
    parameter type rec_t       = logic,
    parameter type fix_t       = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  rec_t rec_in,
    input  fix_t fix,
    output rec_t rec_out
);
    import bslru_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
    localparam logic [IDX_W-1:0] AGE_TOP = IDX_W'(SLOTS - 1);

    logic                   used_reg, used_next;
    logic [HANDLE_BITS-1:0] owner_reg, owner_next;
    logic [IDX_W-1:0]       age_reg, age_next;
    rec_t                   rec_reg, rec_next;

    always_comb
    begin
        used_next  = used_reg;
        owner_next = owner_reg;
        age_next   = age_reg;
        rec_next   = rec_in;

        if (rec_in.valid && !rec_in.apply)
        begin
            // Gather sweep: add this slot's view to the passing record.
            if (used_reg && (owner_reg == rec_in.handle) && !rec_in.hit_found)
            begin
                rec_next.hit_found = 1'b1;
                rec_next.hit_idx   = MY_IDX;
                rec_next.hit_age   = age_reg;
            end
            if (used_reg)
            begin
                rec_next.used_cnt = rec_in.used_cnt + 1'b1;
            end
            else
            begin
                rec_next.free_found = 1'b1;
                rec_next.free_idx   = MY_IDX;
            end
            if ((age_reg == '0) && !rec_in.zero_found)
            begin
                rec_next.zero_found = 1'b1;
                rec_next.zero_idx   = MY_IDX;
                rec_next.zero_owner = owner_reg;
            end
        end
        else if (rec_in.valid && rec_in.apply)
        begin
            // Apply sweep: each slot performs its own part of the decision.
            case (rec_in.mode)
                MODE_HIT:
                begin
                    if (used_reg && (age_reg > rec_in.tgt_age))
                    begin
                        age_next       = age_reg - 1'b1;
                        rec_next.s_cnt = rec_in.s_cnt + 1'b1;
                    end
                end
                MODE_FREE:
                begin
                    if (rec_in.tgt_idx == MY_IDX)
                    begin
                        used_next  = 1'b1;
                        owner_next = rec_in.handle;
                        age_next   = rec_in.tgt_age;
                    end
                end
                MODE_EVICT:
                begin
                    if (rec_in.take && (rec_in.tgt_idx == MY_IDX))
                    begin
                        owner_next = rec_in.handle;
                        age_next   = AGE_TOP;
                    end
                    else if (age_reg != '0)
                    begin
                        age_next = age_reg - 1'b1;
                    end
                end
                MODE_RELEASE:
                begin
                    if (rec_in.tgt_idx == MY_IDX)
                    begin
                        used_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Final age of a promoted slot arrives after the apply sweep.
        if (fix.valid && (fix.idx == MY_IDX))
        begin
            age_next = fix.age;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            age_reg  <= '0;
            rec_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            age_reg  <= age_next;
            rec_reg  <= rec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg <= owner_next;
    end

    assign rec_out = rec_reg;

endmodule
